[rtl/rdc_pkg.sv]
// Shared constants, types and the reciprocal table of the radix digit converter.
package rdc_pkg;

    localparam int MAX_IN_DIGITS  = 9;
    localparam int MAX_OUT_DIGITS = 19;

    localparam int SRC_W       = 30;
    localparam int BASE_W      = 4;
    localparam int OUT_W       = 64;
    localparam int STATUS_W    = 3;
    localparam int RECIP_SHIFT = 34;
    localparam int RECIP_W     = 34;
    localparam int PROD_W      = SRC_W + RECIP_SHIFT;
    localparam int CNT_W       = $clog2(MAX_OUT_DIGITS + 2);

    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(10);
    localparam logic [BASE_W-1:0] DEC_BASE = BASE_W'(10);

    // Smallest value with MAX_OUT_DIGITS + 1 decimal digits.
    localparam logic [OUT_W-1:0] OUT_LIMIT = 64'd10000000000000000000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BAD_SRC_BASE = 3'd1,
        ST_BAD_DIGIT    = 3'd2,
        ST_BAD_DST_BASE = 3'd3,
        ST_OVERFLOW     = 3'd4
    } status_t;

    typedef struct packed {
        logic [SRC_W-1:0]  source_digits;
        logic [BASE_W-1:0] source_base;
        logic [BASE_W-1:0] target_base;
        logic              src_base_ok;
        logic              dst_base_ok;
    } rdc_item_t;

    typedef struct packed {
        logic has_item;
        logic has_room;
    } rdc_q_stat_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_IN_MUL,
        BK_IN_DIV,
        BK_OUT_MUL,
        BK_OUT_DIV,
        BK_DONE
    } bk_state_t;

    function automatic logic base_ok(input logic [BASE_W-1:0] b);
        return (b >= MIN_BASE) && (b <= MAX_BASE);
    endfunction

    // ceil(2^34 / b). For any dividend below 2^30 the product shifted right by
    // 34 is the exact quotient, since the rounding error stays below 1/16.
    function automatic logic [RECIP_W-1:0] recip(input logic [BASE_W-1:0] b);
        logic [RECIP_W-1:0] r;
        unique case (b)
            4'd2:    r = 34'd8589934592;
            4'd3:    r = 34'd5726623062;
            4'd4:    r = 34'd4294967296;
            4'd5:    r = 34'd3435973837;
            4'd6:    r = 34'd2863311531;
            4'd7:    r = 34'd2454267027;
            4'd8:    r = 34'd2147483648;
            4'd9:    r = 34'd1908874354;
            4'd10:   r = 34'd1717986919;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/rdc_if.sv]
// Valid/ready channel interfaces for request and result items.
interface rdc_in_if;
    import rdc_pkg::*;

    logic              valid;
    logic              ready;
    logic [SRC_W-1:0]  source_digits;
    logic [BASE_W-1:0] source_base;
    logic [BASE_W-1:0] target_base;

    modport source (output valid, output source_digits, output source_base,
                    output target_base, input ready);
    modport sink (input valid, input source_digits, input source_base,
                  input target_base, output ready);
endinterface

interface rdc_out_if;
    import rdc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_W-1:0]    converted_digits;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output converted_digits, output status, input ready);
    modport sink (input valid, input converted_digits, input status, output ready);
endinterface

[rtl/rdc_front.sv]
// Front end: accepts request items, checks both bases and hands them to the queue.
module rdc_front (
    input  logic                clk,
    input  logic                rst_n,
    rdc_in_if.sink              request,
    input  rdc_pkg::rdc_q_stat_t q_stat,
    output rdc_pkg::rdc_item_t  push_item,
    output logic                push
);
    import rdc_pkg::*;

    rdc_item_t hold_reg;
    rdc_item_t hold_next;
    logic      hold_valid_reg;
    logic      hold_valid_next;
    logic      accept;

    assign request.ready = !hold_valid_reg || q_stat.has_room;
    assign accept        = request.valid && request.ready;
    assign push          = hold_valid_reg && q_stat.has_room;
    assign push_item     = hold_reg;

    always_comb
    begin
        hold_next.source_digits = request.source_digits;
        hold_next.source_base   = request.source_base;
        hold_next.target_base   = request.target_base;
        hold_next.src_base_ok   = base_ok(request.source_base);
        hold_next.dst_base_ok   = base_ok(request.target_base);
        hold_valid_next         = accept || (hold_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

endmodule

[rtl/rdc_queue.sv]
// Two-entry queue of classified items between the front end and the converter.
module rdc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rdc_pkg::rdc_item_t   push_item,
    input  logic                 pop,
    output rdc_pkg::rdc_item_t   head_item,
    output rdc_pkg::rdc_q_stat_t q_stat
);
    import rdc_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    rdc_item_t            slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_stat.has_item = (cnt_reg != '0);
    assign q_stat.has_room = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign do_push         = push && q_stat.has_room;
    assign do_pop          = pop && q_stat.has_item;
    assign head_item       = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/rdc_back.sv]
// Converter: reads source digits, rebuilds the value and writes it out in the target base.
module rdc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rdc_pkg::rdc_q_stat_t q_stat,
    input  rdc_pkg::rdc_item_t   head_item,
    output logic                 pop,
    rdc_out_if.source            result
);
    import rdc_pkg::*;

    bk_state_t          state_reg, state_next;
    logic [SRC_W-1:0]   cur_reg, cur_next;
    logic [BASE_W-1:0]  div_reg, div_next;
    logic [BASE_W-1:0]  sb_reg, sb_next;
    logic [BASE_W-1:0]  tb_reg, tb_next;
    logic               tb_ok_reg, tb_ok_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [BASE_W-1:0]  r_reg, r_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SRC_W-1:0]   value_reg, value_next;
    logic [SRC_W-1:0]   weight_reg, weight_next;
    logic [OUT_W-1:0]   packed_reg, packed_next;
    logic [OUT_W-1:0]   place_reg, place_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_digits_reg, out_digits_next;
    status_t            out_status_reg, out_status_next;

    logic [SRC_W-1:0]   quot;
    logic [SRC_W-1:0]   quot_times_div;
    logic [SRC_W-1:0]   rem_full;
    logic [SRC_W-1:0]   value_sum;
    logic [SRC_W-1:0]   weight_mul;
    logic [OUT_W-1:0]   packed_sum;
    logic [OUT_W-1:0]   place_x10;
    logic [CNT_W-1:0]   cnt_inc;

    assign result.valid            = out_valid_reg;
    assign result.converted_digits = out_digits_reg;
    assign result.status           = out_status_reg;

    // Quotient and remainder of cur_reg by div_reg, from the registered product.
    assign quot           = prod_reg[PROD_W-1 -: SRC_W];
    assign quot_times_div = SRC_W'(quot * SRC_W'(div_reg));
    assign rem_full       = cur_reg - quot_times_div;

    assign value_sum  = value_reg + SRC_W'(weight_reg * SRC_W'(r_reg));
    assign weight_mul = SRC_W'(weight_reg * SRC_W'(sb_reg));
    assign packed_sum = packed_reg + OUT_W'(place_reg * OUT_W'(r_reg));
    assign place_x10  = (place_reg << 3) + (place_reg << 1);
    assign cnt_inc    = cnt_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        div_next        = div_reg;
        sb_next         = sb_reg;
        tb_next         = tb_reg;
        tb_ok_next      = tb_ok_reg;
        prod_next       = PROD_W'(cur_reg) * PROD_W'(recip(div_reg));
        r_next          = r_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        value_next      = value_reg;
        weight_next     = weight_reg;
        packed_next     = packed_reg;
        place_next      = place_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_digits_next = out_digits_reg;
        out_status_next = out_status_reg;
        pop             = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_stat.has_item)
                begin
                    pop         = 1'b1;
                    cur_next    = head_item.source_digits;
                    div_next    = DEC_BASE;
                    sb_next     = head_item.source_base;
                    tb_next     = head_item.target_base;
                    tb_ok_next  = head_item.dst_base_ok;
                    pend_next   = 1'b0;
                    cnt_next    = '0;
                    value_next  = '0;
                    weight_next = SRC_W'(1);
                    status_next = ST_OK;
                    if (!head_item.src_base_ok)
                    begin
                        status_next = ST_BAD_SRC_BASE;
                        state_next  = BK_DONE;
                    end
                    else
                    begin
                        state_next = BK_IN_MUL;
                    end
                end
            end

            BK_IN_MUL:
            begin
                if (!pend_reg)
                begin
                    state_next = BK_IN_DIV;
                end
                else if (r_reg >= sb_reg)
                begin
                    status_next = ST_BAD_DIGIT;
                    state_next  = BK_DONE;
                end
                else
                begin
                    value_next  = value_sum;
                    weight_next = weight_mul;
                    cnt_next    = cnt_inc;
                    // Once the remaining source digits are all zero they add nothing.
                    if (cur_reg == '0 || cnt_inc == CNT_W'(MAX_IN_DIGITS))
                    begin
                        if (!tb_ok_reg)
                        begin
                            status_next = ST_BAD_DST_BASE;
                            state_next  = BK_DONE;
                        end
                        else
                        begin
                            cur_next    = value_sum;
                            div_next    = tb_reg;
                            cnt_next    = '0;
                            pend_next   = 1'b0;
                            packed_next = '0;
                            place_next  = OUT_W'(1);
                            state_next  = BK_OUT_MUL;
                        end
                    end
                    else
                    begin
                        state_next = BK_IN_DIV;
                    end
                end
            end

            BK_IN_DIV, BK_OUT_DIV:
            begin
                cur_next   = quot;
                r_next     = rem_full[BASE_W-1:0];
                pend_next  = 1'b1;
                state_next = (state_reg == BK_IN_DIV) ? BK_IN_MUL : BK_OUT_MUL;
            end

            BK_OUT_MUL:
            begin
                if (!pend_reg)
                begin
                    state_next = BK_OUT_DIV;
                end
                else
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc > CNT_W'(MAX_OUT_DIGITS))
                    begin
                        status_next = ST_OVERFLOW;
                        state_next  = BK_DONE;
                    end
                    else
                    begin
                        packed_next = packed_sum;
                        place_next  = place_x10;
                        state_next  = (cur_reg == '0) ? BK_DONE : BK_OUT_DIV;
                    end
                end
            end

            BK_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_digits_next = (status_reg == ST_OK) ? packed_reg : '0;
                    state_next      = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        div_reg        <= div_next;
        sb_reg         <= sb_next;
        tb_reg         <= tb_next;
        tb_ok_reg      <= tb_ok_next;
        prod_reg       <= prod_next;
        r_reg          <= r_next;
        value_reg      <= value_next;
        weight_reg     <= weight_next;
        packed_reg     <= packed_next;
        place_reg      <= place_next;
        status_reg     <= status_next;
        out_digits_reg <= out_digits_next;
        out_status_reg <= out_status_next;
    end

endmodule

[rtl/radix_digit_converter_top.sv]
// Top level of the radix digit converter: front end, item queue and converter.
//
//  Channel   Dir  Payload                                    Handshake
//  request   in   source_digits[29:0], source_base[3:0],     valid/ready
//                 target_base[3:0]
//  result    out  converted_digits[63:0], status[2:0]        valid/ready
//
// In the converter, a conversion reads n source digits (up to nine) and writes m target
// digits (up to twenty, the last one tripping overflow). Each digit passes through a
// reciprocal multiply state and a quotient/remainder state. A bad source base skips both
// digit loops; a bad digit or a bad target base ends the conversion in the source loop.
// Reset clears all control state at once. The front end and a two-entry queue keep taking
// items while the converter is busy or a result waits in the output register.
module radix_digit_converter_top (
    input  logic      clk,
    input  logic      rst_n,
    rdc_in_if.sink    request,
    rdc_out_if.source result
);
    import rdc_pkg::*;

    rdc_q_stat_t q_stat;
    rdc_item_t   push_item;
    rdc_item_t   head_item;
    logic        push;
    logic        pop;

    rdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .q_stat    (q_stat),
        .push_item (push_item),
        .push      (push)
    );

    rdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    rdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_item (head_item),
        .pop       (pop),
        .result    (result)
    );

    // Any failed check must zero the digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |-> (result.converted_digits == '0))
        else $error("error result carries nonzero digits");

    // A good result never has more than the allowed number of target digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_OK) |-> (result.converted_digits < OUT_LIMIT))
        else $error("good result exceeds the digit limit");

    // A single-digit result is below ten, so its low four bits are at most nine.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.converted_digits[3:0] <= 4'd9
                          || result.converted_digits >= 64'd10))
        else $error("single-digit result is not a decimal digit");

endmodule
